[design/page_buffer_sprite_blitter_defines.svh]
// Assertion macros for the page buffer sprite blitter checker.
// Depends on nothing; the including module supplies i_clk and i_rst_n.
`ifndef PAGE_BUFFER_SPRITE_BLITTER_DEFINES_SVH
`define PAGE_BUFFER_SPRITE_BLITTER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PBSB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pbsb check failed");

// Next-cycle implication, checked outside reset.
`define PBSB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pbsb check failed");

`endif

[design/pbsb_pkg.sv]
// Shared types, codes and helpers for the page buffer sprite blitter.
// No dependencies.
`timescale 1ns / 1ps
package pbsb_pkg;

    localparam int SCREEN_WIDTH_DEF  = 128;
    localparam int SCREEN_HEIGHT_DEF = 64;
    // Field widths cover the largest screen allowed (512 columns, 32 pages).
    localparam int COL_W  = 9;
    localparam int PAGE_W = 5;

    typedef enum logic [2:0] {
        K_PIXEL  = 3'd0,
        K_FILL   = 3'd1,
        K_VLINE  = 3'd2,
        K_BCLR   = 3'd3,
        K_SOLID  = 3'd4,
        K_SPRITE = 3'd5,
        K_READ   = 3'd6,
        K_SPARE  = 3'd7
    } t_kind;

    typedef enum logic [2:0] {
        J_NONE  = 3'd0,
        J_RMW   = 3'd1,
        J_VLINE = 3'd2,
        J_FILL  = 3'd3,
        J_READ  = 3'd4
    } t_job_kind;

    typedef struct packed {
        t_job_kind          kind;
        logic [COL_W-1:0]   col;
        logic [PAGE_W-1:0]  first;
        logic [PAGE_W-1:0]  last;
        logic               hit;
        logic [7:0]         clr_a;
        logic [7:0]         set_a;
        logic [7:0]         clr_b;
        logic [7:0]         set_b;
        logic [2:0]         top_lo;
        logic [2:0]         bot_lo;
    } t_job;

    function automatic logic [7:0] vline_mask(
        input logic [PAGE_W-1:0] pg,
        input logic [PAGE_W-1:0] first,
        input logic [PAGE_W-1:0] last,
        input logic [2:0]        top_lo,
        input logic [2:0]        bot_lo
    );
        logic [7:0] m;
        m = 8'hFF;
        if (pg == first) m = m & (8'hFF << top_lo);
        if (pg == last)  m = m & (8'hFF >> (3'd7 - bot_lo));
        return m;
    endfunction

endpackage

[design/pbsb_front.sv]
// Front end: accepts drawing words, clips them and turns them into frame jobs.
// Depends on pbsb_pkg.
`timescale 1ns / 1ps
module pbsb_front #(
    parameter int SCREEN_WIDTH  = pbsb_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = pbsb_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic               i_push,
    input  logic               i_q_full,
    input  logic               i_clearing,
    input  logic [2:0]         i_kind,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic signed [7:0]  i_end_y,
    input  logic [7:0]         i_col_offset,
    input  logic [4:0]         i_page_index,
    input  logic [7:0]         i_sprite_height,
    input  logic [7:0]         i_src_byte,
    input  logic [7:0]         i_mask_byte,
    output logic               o_full,
    output logic               o_job_valid,
    output pbsb_pkg::t_job     o_job
);
    localparam int PAGES = (SCREEN_HEIGHT + 7) / 8;
    localparam logic signed [17:0] W18 = 18'(SCREEN_WIDTH);
    localparam logic signed [17:0] H18 = 18'(SCREEN_HEIGHT);
    localparam logic signed [17:0] P18 = 18'(PAGES);

    logic signed [17:0] x18, y18, ey18, top, bot, top_c, bot_c, dx, base, b8;
    logic               x_in, dx_in, last_pg, b_skip, slot0, slot1;
    logic [5:0]         pages6, dp1;
    logic [2:0]         sh;
    logic [7:0]         hmask, region, fill, bit8;
    logic [15:0]        wide_clr, wide_set;
    pbsb_pkg::t_job     job;

    assign x18  = {{2{i_pos_x[15]}}, i_pos_x};
    assign y18  = {{2{i_pos_y[15]}}, i_pos_y};
    assign ey18 = {{10{i_end_y[7]}}, i_end_y};
    assign x_in = (x18 >= 18'sd0) && (x18 < W18);
    assign bit8 = 8'h01 << y18[2:0];

    // line ends in either order, clipped to the screen
    assign top   = (y18 < ey18) ? y18 : ey18;
    assign bot   = (y18 < ey18) ? ey18 : y18;
    assign top_c = (top < 18'sd0) ? 18'sd0 : top;
    assign bot_c = (bot >= H18) ? (H18 - 18'sd1) : bot;

    // bitmap byte placement
    assign pages6  = 6'((9'(i_sprite_height) + 9'd7) >> 3);
    assign dx      = x18 + $signed({10'd0, i_col_offset});
    assign dx_in   = (dx >= 18'sd0) && (dx < W18);
    assign base    = y18 + $signed({10'd0, i_page_index, 3'b000});
    assign last_pg = (({1'b0, i_page_index} + 6'd1) == pages6);
    assign hmask   = (last_pg && (i_sprite_height[2:0] != 3'd0))
                   ? ((8'h01 << i_sprite_height[2:0]) - 8'h01) : 8'hFF;
    assign b_skip  = (i_sprite_height == 8'd0) || ({1'b0, i_page_index} >= pages6)
                   || !dx_in || (base <= -18'sd8) || (base >= H18);
    assign b8      = base + 18'sd8;
    assign dp1     = b8[8:3];
    assign sh      = b8[2:0];
    assign slot0   = (dp1 != 6'd0);
    assign slot1   = (sh != 3'd0) && (dp1 < 6'(PAGES));

    always_comb begin
        unique case (pbsb_pkg::t_kind'(i_kind))
            pbsb_pkg::K_BCLR: begin
                region = i_src_byte & hmask;
                fill   = 8'h00;
            end
            pbsb_pkg::K_SOLID: begin
                region = hmask;
                fill   = ~i_src_byte & hmask;
            end
            default: begin
                region = i_mask_byte & hmask;
                fill   = i_src_byte & i_mask_byte & hmask;
            end
        endcase
    end

    assign wide_clr = {8'h00, region} << sh;
    assign wide_set = {8'h00, fill} << sh;

    always_comb begin
        job = '0;
        job.kind = pbsb_pkg::J_NONE;
        unique case (pbsb_pkg::t_kind'(i_kind)) inside
            pbsb_pkg::K_PIXEL: begin
                job.col   = x18[pbsb_pkg::COL_W-1:0];
                job.first = y18[pbsb_pkg::PAGE_W+2:3];
                job.last  = y18[pbsb_pkg::PAGE_W+2:3];
                job.clr_a = bit8;
                job.set_a = (i_src_byte != 8'h00) ? bit8 : 8'h00;
                if (x_in && (y18 >= 18'sd0) && (y18 < H18)) job.kind = pbsb_pkg::J_RMW;
            end
            pbsb_pkg::K_FILL: begin
                job.kind  = pbsb_pkg::J_FILL;
                job.set_a = (i_src_byte != 8'h00) ? 8'hFF : 8'h00;
            end
            pbsb_pkg::K_VLINE: begin
                job.col    = x18[pbsb_pkg::COL_W-1:0];
                job.first  = top_c[pbsb_pkg::PAGE_W+2:3];
                job.last   = bot_c[pbsb_pkg::PAGE_W+2:3];
                job.top_lo = top_c[2:0];
                job.bot_lo = bot_c[2:0];
                job.set_a  = i_src_byte;
                if ((i_src_byte != 8'h00) && x_in && (bot >= 18'sd0) && (top < H18))
                    job.kind = pbsb_pkg::J_VLINE;
            end
            pbsb_pkg::K_BCLR, pbsb_pkg::K_SOLID, pbsb_pkg::K_SPRITE: begin
                job.col = dx[pbsb_pkg::COL_W-1:0];
                if (slot0) begin
                    job.first = 5'(dp1 - 6'd1);
                    job.last  = 5'(dp1 - 6'd1) + {4'd0, slot1};
                    job.clr_a = wide_clr[7:0];
                    job.set_a = wide_set[7:0];
                    job.clr_b = wide_clr[15:8];
                    job.set_b = wide_set[15:8];
                end else begin
                    job.first = dp1[pbsb_pkg::PAGE_W-1:0];
                    job.last  = dp1[pbsb_pkg::PAGE_W-1:0];
                    job.clr_a = wide_clr[15:8];
                    job.set_a = wide_set[15:8];
                end
                if (!b_skip && (region != 8'h00) && (slot0 || slot1))
                    job.kind = pbsb_pkg::J_RMW;
            end
            pbsb_pkg::K_READ: begin
                job.kind  = pbsb_pkg::J_READ;
                job.col   = x18[pbsb_pkg::COL_W-1:0];
                job.first = y18[pbsb_pkg::PAGE_W-1:0];
                job.last  = y18[pbsb_pkg::PAGE_W-1:0];
                job.hit   = x_in && (y18 >= 18'sd0) && (y18 < P18);
            end
            default: job.kind = pbsb_pkg::J_NONE;
        endcase
    end

    assign o_full      = i_q_full || i_clearing;
    // drop words that touch nothing
    assign o_job_valid = i_push && !o_full && (job.kind != pbsb_pkg::J_NONE);
    assign o_job       = job;

endmodule

[design/pbsb_queue.sv]
// Two-entry job queue between the front end and the frame engine.
// Depends on pbsb_pkg.
`timescale 1ns / 1ps
module pbsb_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pbsb_pkg::t_job i_data,
    output logic           o_full,
    input  logic           i_pop,
    output pbsb_pkg::t_job o_data,
    output logic           o_empty
);
    pbsb_pkg::t_job r_slot [2];
    logic           r_wr_ptr, r_rd_ptr;
    logic [1:0]     r_count;
    logic           do_push, do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) r_slot[r_wr_ptr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) r_wr_ptr <= ~r_wr_ptr;
            if (do_pop)  r_rd_ptr <= ~r_rd_ptr;
            r_count <= r_count + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

[design/pbsb_back.sv]
// Frame engine: owns the frame memory and runs read-modify-write, fill and read jobs.
// Depends on pbsb_pkg.
`timescale 1ns / 1ps
module pbsb_back #(
    parameter int SCREEN_WIDTH  = pbsb_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = pbsb_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    input  pbsb_pkg::t_job i_job,
    output logic           o_job_pop,
    output logic           o_clearing,
    input  logic           i_pop,
    output logic           o_empty,
    output logic [7:0]     o_read_data
);
    localparam int PAGES = (SCREEN_HEIGHT + 7) / 8;
    localparam int DEPTH = SCREEN_WIDTH * PAGES;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_RD    = 5'b00100,
        S_WR    = 5'b01000,
        S_FILL  = 5'b10000
    } t_state;

    t_state                      r_state, n_state;
    logic [AW-1:0]               r_cnt, n_cnt;
    logic [7:0]                  r_fill_val, n_fill_val;
    pbsb_pkg::t_job              r_job, n_job;
    logic [pbsb_pkg::PAGE_W-1:0] r_pg, n_pg;
    logic                        r_out_valid, n_out_valid;
    logic [7:0]                  r_out_data, n_out_data;

    logic [7:0]    r_mem [DEPTH];
    logic [7:0]    r_rdata;
    logic          we;
    logic [AW-1:0] addr, job_addr;
    logic [7:0]    wdata, clr, set;

    assign job_addr = AW'(r_job.col) + AW'(AW'(r_pg) * AW'(SCREEN_WIDTH));

    always_comb begin
        if (r_job.kind == pbsb_pkg::J_VLINE) begin
            clr = 8'h00;
            set = r_job.set_a & pbsb_pkg::vline_mask(r_pg, r_job.first, r_job.last,
                                                     r_job.top_lo, r_job.bot_lo);
        end else if (r_pg == r_job.first) begin
            clr = r_job.clr_a;
            set = r_job.set_a;
        end else begin
            clr = r_job.clr_b;
            set = r_job.set_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[addr] <= wdata;
        r_rdata <= r_mem[addr];
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_fill_val  = r_fill_val;
        n_job       = r_job;
        n_pg        = r_pg;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        o_job_pop   = 1'b0;
        we          = 1'b0;
        addr        = job_addr;
        wdata       = (r_rdata & ~clr) | set;
        if (i_pop && r_out_valid) n_out_valid = 1'b0;
        unique case (r_state) inside
            S_CLEAR, S_FILL: begin
                we    = 1'b1;
                addr  = r_cnt;
                wdata = r_fill_val;
                n_cnt = r_cnt + AW'(1);
                if (r_cnt == AW'(DEPTH - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_job_valid) begin
                    unique case (i_job.kind) inside
                        pbsb_pkg::J_FILL: begin
                            o_job_pop  = 1'b1;
                            n_fill_val = i_job.set_a;
                            n_cnt      = '0;
                            n_state    = S_FILL;
                        end
                        pbsb_pkg::J_READ: begin
                            // wait for the result register to drain
                            if (!r_out_valid) begin
                                o_job_pop = 1'b1;
                                n_job     = i_job;
                                n_pg      = i_job.first;
                                if (i_job.hit) begin
                                    n_state = S_RD;
                                end else begin
                                    n_out_valid = 1'b1;
                                    n_out_data  = 8'h00;
                                end
                            end
                        end
                        pbsb_pkg::J_RMW, pbsb_pkg::J_VLINE: begin
                            o_job_pop = 1'b1;
                            n_job     = i_job;
                            n_pg      = i_job.first;
                            n_state   = S_RD;
                        end
                        default: o_job_pop = 1'b1;
                    endcase
                end
            end
            S_RD: n_state = S_WR;
            S_WR: begin
                if (r_job.kind == pbsb_pkg::J_READ) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_rdata;
                    n_state     = S_IDLE;
                end else begin
                    we = 1'b1;
                    if (r_pg == r_job.last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_pg    = r_pg + {{(pbsb_pkg::PAGE_W-1){1'b0}}, 1'b1};
                        n_state = S_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_fill_val  <= 8'h00;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_fill_val  <= n_fill_val;
            r_out_valid <= n_out_valid;
        end
        r_job      <= n_job;
        r_pg       <= n_pg;
        r_out_data <= n_out_data;
    end

    assign o_clearing  = (r_state == S_CLEAR);
    assign o_empty     = !r_out_valid;
    assign o_read_data = r_out_data;

endmodule

[design/page_buffer_sprite_blitter.sv]
// Top level of the page buffer sprite blitter: front end, job queue, frame engine.
// Depends on pbsb_pkg, pbsb_front, pbsb_queue and pbsb_back.
//
//  channel  | direction | handshake          | word
//  ---------+-----------+--------------------+------------------------------------
//  command  | in        | push / full        | i_kind .. i_mask_byte
//  result   | out       | empty / pop        | o_read_data
//
// Each job leaves the queue from the idle state, then passes a read state and a write state
// per frame byte: a pixel touches one byte, a bitmap byte one or two, a line one per page,
// a read one (a read outside the screen answers zero from idle). Fill sweeps one byte a cycle.
// After reset a clearing pass zeroes every frame byte with full held high.
// A two-word job queue lets commands enter while the engine works; a result left
// waiting holds the next read at the queue head, stalling the engine and then the input.
`timescale 1ns / 1ps
module page_buffer_sprite_blitter #(
    parameter int SCREEN_WIDTH  = pbsb_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = pbsb_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [2:0]         i_kind,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic signed [7:0]  i_end_y,
    input  logic [7:0]         i_col_offset,
    input  logic [4:0]         i_page_index,
    input  logic [7:0]         i_sprite_height,
    input  logic [7:0]         i_src_byte,
    input  logic [7:0]         i_mask_byte,
    output logic               empty,
    input  logic               pop,
    output logic [7:0]         o_read_data
);
    logic           q_full, q_empty, q_pop, clearing, job_valid;
    pbsb_pkg::t_job job_in, job_out;

    pbsb_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_front (
        .i_push          (push),
        .i_q_full        (q_full),
        .i_clearing      (clearing),
        .i_kind          (i_kind),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_end_y         (i_end_y),
        .i_col_offset    (i_col_offset),
        .i_page_index    (i_page_index),
        .i_sprite_height (i_sprite_height),
        .i_src_byte      (i_src_byte),
        .i_mask_byte     (i_mask_byte),
        .o_full          (full),
        .o_job_valid     (job_valid),
        .o_job           (job_in)
    );

    pbsb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_valid),
        .i_data  (job_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (job_out),
        .o_empty (q_empty)
    );

    pbsb_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!q_empty),
        .i_job       (job_out),
        .o_job_pop   (q_pop),
        .o_clearing  (clearing),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_read_data (o_read_data)
    );

endmodule

[design/pbsb_checker.sv]
// Port-level checks for the page buffer sprite blitter, bound to its top level.
// Depends on page_buffer_sprite_blitter_defines.svh.
`timescale 1ns / 1ps
`include "page_buffer_sprite_blitter_defines.svh"
module pbsb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       full,
    input logic       pop,
    input logic       empty,
    input logic [7:0] o_read_data
);
    // a waiting result holds until taken
    `PBSB_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(o_read_data))
    // the clearing pass blocks commands right after reset
    `PBSB_ASSERT_NOW(a_full_after_reset, $rose(i_rst_n), full)
    // no result is waiting straight out of reset
    `PBSB_ASSERT_NOW(a_empty_after_reset, $rose(i_rst_n), empty)
endmodule

bind page_buffer_sprite_blitter pbsb_checker u_pbsb_checker (.*);

[verif/tb.sv]
// Self-checking bench for page_buffer_sprite_blitter: directed table, then random commands.
// Depends on pbsb_pkg and the blitter RTL; predicts the frame store locally.
`timescale 1ns / 1ps
module tb;

    localparam int SW = pbsb_pkg::SCREEN_WIDTH_DEF;
    localparam int SH = pbsb_pkg::SCREEN_HEIGHT_DEF;
    localparam int PAGES = (SH + 7) / 8;
    localparam int CYCLE_LIMIT = 1500000;

    typedef struct {
        pbsb_pkg::t_kind kind;
        logic [15:0]     px;
        logic [15:0]     py;
        logic [7:0]      ey;
        logic [7:0]      col;
        logic [4:0]      pg;
        logic [7:0]      ht;
        logic [7:0]      src;
        logic [7:0]      msk;
        bit              has_exp;
        logic [7:0]      exp_val;
    } t_cmd;

    logic i_clk, i_rst_n, push, pop;
    logic full, empty;
    logic [2:0] i_kind;
    logic signed [15:0] i_pos_x, i_pos_y;
    logic signed [7:0] i_end_y;
    logic [7:0] i_col_offset, i_sprite_height, i_src_byte, i_mask_byte;
    logic [4:0] i_page_index;
    logic [7:0] o_read_data;

    logic [7:0] frame_copy [SW*PAGES];
    logic [7:0] read_backs [$];
    int mismatches;
    int cycles;
    bit calm;
    t_cmd table_rows [$];

    page_buffer_sprite_blitter uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_kind(i_kind), .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_end_y(i_end_y),
        .i_col_offset(i_col_offset), .i_page_index(i_page_index),
        .i_sprite_height(i_sprite_height), .i_src_byte(i_src_byte),
        .i_mask_byte(i_mask_byte), .empty(empty), .pop(pop), .o_read_data(o_read_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic void frame_rmw(int c, int p, logic [7:0] clr, logic [7:0] set);
        if (c < 0 || c >= SW || p < 0 || p >= PAGES) return;
        frame_copy[c + p*SW] = (frame_copy[c + p*SW] & ~clr) | set;
    endfunction

    // Apply one command to the local frame copy; returns the byte for a read.
    function automatic logic [7:0] frame_apply(t_cmd c);
        int x, y, e, top, bot, first, last, dx, base, dpage, npages;
        int sh;
        logic [7:0] m, hm, region, fillv, res;
        x = $signed(c.px);
        y = $signed(c.py);
        e = $signed(c.ey);
        res = 8'h00;
        case (c.kind) inside
            pbsb_pkg::K_PIXEL: if (x >= 0 && x < SW && y >= 0 && y < SH)
                frame_rmw(x, y >>> 3, 8'h1 << (y & 7), (c.src != 0) ? 8'h1 << (y & 7) : 8'h0);
            pbsb_pkg::K_FILL: foreach (frame_copy[i])
                frame_copy[i] = (c.src != 0) ? 8'hFF : 8'h00;
            pbsb_pkg::K_VLINE: begin
                top = (y < e) ? y : e;
                bot = (y < e) ? e : y;
                if (c.src != 0 && x >= 0 && x < SW && bot >= 0 && top < SH) begin
                    if (top < 0) top = 0;
                    if (bot >= SH) bot = SH - 1;
                    first = top / 8;
                    last = bot / 8;
                    for (int p = first; p <= last; p++) begin
                        m = 8'hFF;
                        if (p == first) m &= 8'hFF << (top & 7);
                        if (p == last) m &= 8'hFF >> (7 - (bot & 7));
                        frame_rmw(x, p, 8'h00, c.src & m);
                    end
                end
            end
            pbsb_pkg::K_BCLR, pbsb_pkg::K_SOLID, pbsb_pkg::K_SPRITE: begin
                npages = (int'(c.ht) + 7) >> 3;
                dx = x + int'(c.col);
                base = y + 8*int'(c.pg);
                if (c.ht != 0 && c.pg < npages && dx >= 0 && dx < SW && base > -8
                        && base < SH) begin
                    hm = 8'hFF;
                    if (c.pg + 1 == npages && c.ht[2:0] != 0)
                        hm = 8'((8'h1 << c.ht[2:0]) - 8'h1);
                    if (c.kind == pbsb_pkg::K_BCLR) begin
                        region = c.src & hm;
                        fillv = 8'h00;
                    end else if (c.kind == pbsb_pkg::K_SOLID) begin
                        region = hm;
                        fillv = ~c.src & hm;
                    end else begin
                        region = c.msk & hm;
                        fillv = c.src & region;
                    end
                    if (c.kind == pbsb_pkg::K_SOLID || region != 0) begin
                        dpage = ((base + 8) >>> 3) - 1;
                        sh = (base + 8) & 7;
                        frame_rmw(dx, dpage, region << sh, fillv << sh);
                        if (sh != 0)
                            frame_rmw(dx, dpage + 1, region >> (8 - sh), fillv >> (8 - sh));
                    end
                end
            end
            pbsb_pkg::K_READ: if (x >= 0 && x < SW && y >= 0 && y < PAGES)
                res = frame_copy[x + y*SW];
            default: ;
        endcase
        return res;
    endfunction

    function automatic t_cmd mk(pbsb_pkg::t_kind k, int x, int y, int e, int col, int pg,
                                int ht, int src, int msk);
        t_cmd c;
        c.kind = k; c.px = 16'(x); c.py = 16'(y); c.ey = 8'(e); c.col = 8'(col);
        c.pg = 5'(pg); c.ht = 8'(ht); c.src = 8'(src); c.msk = 8'(msk);
        c.has_exp = 1'b0; c.exp_val = 8'h00;
        return c;
    endfunction

    function automatic t_cmd mk_read(int x, int y, int v);
        t_cmd c;
        c = mk(pbsb_pkg::K_READ, x, y, 0, 0, 0, 1, 0, 0);
        c.has_exp = 1'b1;
        c.exp_val = 8'(v);
        return c;
    endfunction

    function automatic t_cmd rand_cmd();
        t_cmd c;
        int r;
        r = $urandom_range(99);
        c = mk(pbsb_pkg::K_PIXEL, $urandom_range(SW + 8) - 4, $urandom_range(SH + 8) - 4,
               $urandom_range(SH + 8) - 4, $urandom_range(15), $urandom_range(3),
               $urandom_range(1, 32), $urandom, $urandom);
        if (r < 15) c.kind = pbsb_pkg::K_PIXEL;
        else if (r < 16) c.kind = pbsb_pkg::K_FILL;
        else if (r < 28) c.kind = pbsb_pkg::K_VLINE;
        else if (r < 40) c.kind = pbsb_pkg::K_BCLR;
        else if (r < 52) c.kind = pbsb_pkg::K_SOLID;
        else if (r < 66) c.kind = pbsb_pkg::K_SPRITE;
        else if (r < 98) begin
            c.kind = pbsb_pkg::K_READ;
            c.py = 16'($urandom_range(PAGES + 1) - 1);
        end else c.kind = pbsb_pkg::K_SPARE;
        // occasional wide values so every field bit toggles
        if ($urandom_range(19) == 0) begin
            c.px = 16'($urandom); c.py = 16'($urandom); c.ey = 8'($urandom);
            c.col = 8'($urandom); c.pg = 5'($urandom); c.ht = 8'($urandom);
        end
        c.has_exp = 1'b0;
        return c;
    endfunction

    task automatic send(t_cmd c);
        logic [7:0] v;
        while (!calm && $urandom_range(99) < 16) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push <= 1'b1;
        i_kind <= c.kind; i_pos_x <= c.px; i_pos_y <= c.py; i_end_y <= c.ey;
        i_col_offset <= c.col; i_page_index <= c.pg; i_sprite_height <= c.ht;
        i_src_byte <= c.src; i_mask_byte <= c.msk;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        v = frame_apply(c);
        if (c.kind == pbsb_pkg::K_READ) begin
            if (c.has_exp && v !== c.exp_val) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("table row read: predictor %h, table %h", v, c.exp_val);
            end
            read_backs.push_back(v);
        end
        @(negedge i_clk);
    endtask

    // Result side: pop at random (always while calm), check each accepted word against the oldest read.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (read_backs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected read word %h", o_read_data);
            end else begin
                if (o_read_data !== read_backs[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("read_data: expected %h, got %h", read_backs[0], o_read_data);
                end
                void'(read_backs.pop_front());
            end
        end
    end

    always @(negedge i_clk) pop <= calm ? 1'b1 : ($urandom_range(99) >= 16);

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        mismatches = 0; cycles = 0; calm = 0;
        i_rst_n = 1'b0; push = 1'b0; pop = 1'b0;
        i_kind = pbsb_pkg::K_PIXEL; i_pos_x = '0; i_pos_y = '0; i_end_y = '0;
        i_col_offset = '0; i_page_index = '0; i_sprite_height = 8'd1;
        i_src_byte = '0; i_mask_byte = '0;
        foreach (frame_copy[i]) frame_copy[i] = 8'h00;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        table_rows.push_back(mk_read(0, 0, 8'h00));
        table_rows.push_back(mk_read(SW - 1, PAGES - 1, 8'h00));
        table_rows.push_back(mk(pbsb_pkg::K_PIXEL, 0, 0, 0, 0, 0, 1, 1, 0));
        table_rows.push_back(mk_read(0, 0, 8'h01));
        table_rows.push_back(mk(pbsb_pkg::K_PIXEL, SW - 1, SH - 1, 0, 0, 0, 1, 8'h80, 0));
        table_rows.push_back(mk_read(SW - 1, PAGES - 1, 8'h80));
        table_rows.push_back(mk(pbsb_pkg::K_PIXEL, -32768, 32767, 0, 0, 0, 1, 1, 0));
        table_rows.push_back(mk(pbsb_pkg::K_FILL, 0, 0, 0, 0, 0, 1, 8'h01, 0));
        table_rows.push_back(mk_read(5, 3, 8'hFF));
        table_rows.push_back(mk_read(-1, 0, 8'h00));
        table_rows.push_back(mk_read(0, PAGES, 8'h00));
        table_rows.push_back(mk(pbsb_pkg::K_FILL, 0, 0, 0, 0, 0, 1, 0, 0));
        table_rows.push_back(mk(pbsb_pkg::K_VLINE, 10, 70, -128, 0, 0, 1, 8'hFF, 0));
        table_rows.push_back(mk(pbsb_pkg::K_VLINE, 11, 3, 12, 0, 0, 1, 8'hA5, 0));
        table_rows.push_back(mk(pbsb_pkg::K_VLINE, SW, 0, 5, 0, 0, 1, 8'hFF, 0));
        table_rows.push_back(mk(pbsb_pkg::K_BCLR, 8, -3, 0, 2, 0, 8, 8'hF0, 0));
        table_rows.push_back(mk(pbsb_pkg::K_SOLID, 12, 5, 0, 255, 0, 255, 8'h3C, 0));
        table_rows.push_back(mk(pbsb_pkg::K_SOLID, 12, 13, 0, 1, 1, 13, 8'h00, 0));
        table_rows.push_back(mk(pbsb_pkg::K_SPRITE, 10, -7, 0, 0, 0, 3, 8'hFF, 8'hFF));
        table_rows.push_back(mk(pbsb_pkg::K_SPRITE, 10, -8, 0, 0, 0, 8, 8'hFF, 8'hFF));
        table_rows.push_back(mk(pbsb_pkg::K_SPRITE, 11, 60, 0, 0, 31, 255, 8'h55, 8'hFF));
        table_rows.push_back(mk(pbsb_pkg::K_SOLID, 9, 0, 0, 0, 0, 0, 8'h00, 0));
        table_rows.push_back(mk(pbsb_pkg::K_SPARE, 0, 0, 0, 0, 0, 1, 8'hFF, 8'hFF));
        for (int c = 8; c < 14; c++)
            table_rows.push_back(mk(pbsb_pkg::K_READ, c, 0, 0, 0, 0, 1, 0, 0));
        table_rows.push_back(mk(pbsb_pkg::K_READ, 11, 1, 0, 0, 0, 1, 0, 0));
        foreach (table_rows[i]) send(table_rows[i]);

        for (int n = 0; n < 1900; n++) begin
            calm = (n >= 800 && n < 1000);
            send(rand_cmd());
        end
        calm = 0;
        push <= 1'b0;

        while (read_backs.size() != 0) @(posedge i_clk);
        repeat (SW * PAGES + 50) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
